>>> rtl/p1ts_pkg.sv
// ----------------------------------------------------------------------------
// p1ts_pkg
// Shared widths, latencies and types for the P1 triangle stiffness pipeline.
// ----------------------------------------------------------------------------
package p1ts_pkg;

  // Coordinates and derived quantities
  localparam int CRD_W  = 16;              // Q4.12 coordinate
  localparam int DIF_W  = CRD_W + 1;       // vertex difference
  localparam int PRD_W  = 2 * DIF_W;       // product of two differences
  localparam int SUM_W  = PRD_W + 3;       // sums of products, signed
  localparam int MAG_W  = 35;              // numerator magnitude, |num| < 2^35
  localparam int DEN_W  = 34;              // |det| < 2^33
  localparam int FRAC_W = 16;              // num * 2^16 before halving divisor

  // Divider
  localparam int Q_W    = 32;              // quotient bits kept
  localparam int DIVD_W = MAG_W + FRAC_W + 1;
  localparam int DIVS_W = DEN_W + 1;
  localparam int REM_W  = DIVS_W + Q_W;

  // Latencies: four front stages, then the divider lane
  localparam int FRONT_LAT  = 4;
  localparam int LANE_LAT   = Q_W + 3;
  localparam int PIPE_DEPTH = FRONT_LAT + LANE_LAT;

  // Result limits, Q16.16
  localparam logic [Q_W-1:0] K_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] K_NEG_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Side information carried along a divider lane
  typedef struct packed {
    logic neg;   // numerator negative
    logic deg;   // zero determinant
  } lane_tag_t;

endpackage

>>> rtl/p1ts_div_lane.sv
// ----------------------------------------------------------------------------
// p1ts_div_lane
// Pipelined restoring divider for one stiffness entry: rounds
// mag * 2^15 / den half away from zero, applies sign, saturates to Q16.16.
// ----------------------------------------------------------------------------
module p1ts_div_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [p1ts_pkg::MAG_W-1:0]    mag,
  input  logic [p1ts_pkg::DEN_W-1:0]    den,
  input  p1ts_pkg::lane_tag_t           tag,
  output logic signed [p1ts_pkg::Q_W-1:0] k
);
  import p1ts_pkg::*;

  // Stage A: dividend (mag << 16) + den, divisor 2*den
  logic [DIVD_W-1:0] divd_a_r;
  logic [DIVS_W-1:0] dvs_a_r;
  lane_tag_t         tag_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      divd_a_r <= {mag, {FRAC_W{1'b0}}} + DIVD_W'(den);
      dvs_a_r  <= {den, 1'b0};
      tag_a_r  <= tag;
    end
  end

  // Stage B plus one stage per quotient bit
  logic [REM_W-1:0]  rem_r [0:Q_W];
  logic [Q_W-1:0]    quo_r [0:Q_W];
  logic [DIVS_W-1:0] dvs_r [0:Q_W];
  lane_tag_t         tag_r [0:Q_W];
  logic              ovf_r [0:Q_W];

  // Quotient of 2^32 or more saturates in any case
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(divd_a_r);
      ovf_r[0] <= REM_W'(divd_a_r) >= {dvs_a_r, {Q_W{1'b0}}};
      quo_r[0] <= '0;
      dvs_r[0] <= dvs_a_r;
      tag_r[0] <= tag_a_r;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= Q_W; j++) begin : g_step
      localparam int SH = Q_W - j;
      logic [REM_W-1:0] sub;
      logic             ge;
      logic [Q_W-1:0]   bit_set;

      assign sub     = REM_W'(dvs_r[j-1]) << SH;
      assign ge      = rem_r[j-1] >= sub;
      assign bit_set = Q_W'(1) << SH;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_r[j-1] - sub) : rem_r[j-1];
          quo_r[j] <= ge ? (quo_r[j-1] | bit_set) : quo_r[j-1];
          dvs_r[j] <= dvs_r[j-1];
          tag_r[j] <= tag_r[j-1];
          ovf_r[j] <= ovf_r[j-1];
        end
      end
    end
  endgenerate

  // Final stage: sign, saturation, degenerate zeroing
  logic [Q_W-1:0] quo_f;
  logic [Q_W-1:0] k_nxt;

  assign quo_f = quo_r[Q_W];

  always_comb begin
    if (tag_r[Q_W].deg) begin
      k_nxt = '0;
    end else if (tag_r[Q_W].neg) begin
      if (ovf_r[Q_W] || (quo_f > K_NEG_MIN)) begin
        k_nxt = K_NEG_MIN;
      end else begin
        k_nxt = Q_W'(~quo_f + Q_W'(1));
      end
    end else begin
      if (ovf_r[Q_W] || quo_f[Q_W-1]) begin
        k_nxt = K_POS_MAX;
      end else begin
        k_nxt = quo_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k <= k_nxt;
    end
  end

endmodule

>>> rtl/p1_triangle_stiffness.sv
// ----------------------------------------------------------------------------
// p1_triangle_stiffness
// Laplace element stiffness matrix of a linear triangle, six unique entries.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  in      | in_valid/in_ready, in_x0..in_y2    | input
//  out     | out_valid/out_ready, out_k00..k22, | output
//          | out_degenerate                     |
//
// One beat per cycle in, one per cycle out, unless out_ready stalls the pipeline;
// beats pass in order through the front stages and the 32-step restoring divider lanes.
// rst_n (synchronous) clears only the valid bits.
// The whole pipeline advances together; a stall on out_ready freezes every
// stage and drops in_ready in the same cycle.
// ----------------------------------------------------------------------------
module p1_triangle_stiffness (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_x0,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_y0,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_x1,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_y1,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_x2,
  input  logic signed [p1ts_pkg::CRD_W-1:0]     in_y2,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k00,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k01,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k02,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k11,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k12,
  output logic signed [p1ts_pkg::Q_W-1:0]       out_k22,
  output logic                                  out_degenerate
);
  import p1ts_pkg::*;

  localparam int N_ENT = 6;

  logic en;
  logic vld_r [0:PIPE_DEPTH-1];

  assign en        = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  // Valid bits shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // S1: edge vectors
  logic signed [DIF_W-1:0] a_r, b_r, c_r, d_r, e_r, f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DIF_W'(in_x1) - DIF_W'(in_x0);
      b_r <= DIF_W'(in_y1) - DIF_W'(in_y0);
      c_r <= DIF_W'(in_x2) - DIF_W'(in_x0);
      d_r <= DIF_W'(in_y2) - DIF_W'(in_y0);
      e_r <= DIF_W'(in_x2) - DIF_W'(in_x1);
      f_r <= DIF_W'(in_y2) - DIF_W'(in_y1);
    end
  end

  // S2: products
  logic signed [PRD_W-1:0] ad_r, bc_r, aa_r, bb_r, cc_r, dd_r, ac_r, bd_r, ee_r, ff_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r <= a_r * d_r;
      bc_r <= b_r * c_r;
      aa_r <= a_r * a_r;
      bb_r <= b_r * b_r;
      cc_r <= c_r * c_r;
      dd_r <= d_r * d_r;
      ac_r <= a_r * c_r;
      bd_r <= b_r * d_r;
      ee_r <= e_r * e_r;
      ff_r <= f_r * f_r;
    end
  end

  // S3: determinant and quadratic forms
  logic signed [SUM_W-1:0] det_r, p_r, q_r, r_r, n0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= SUM_W'(ad_r) - SUM_W'(bc_r);
      p_r   <= SUM_W'(cc_r) + SUM_W'(dd_r);
      q_r   <= -(SUM_W'(ac_r) + SUM_W'(bd_r));
      r_r   <= SUM_W'(aa_r) + SUM_W'(bb_r);
      n0_r  <= SUM_W'(ee_r) + SUM_W'(ff_r);
    end
  end

  // S4: numerators split into sign and magnitude, |det|
  logic signed [SUM_W-1:0] num [0:N_ENT-1];
  logic [MAG_W-1:0]        mag_nxt [0:N_ENT-1];
  logic [MAG_W-1:0]        mag_r   [0:N_ENT-1];
  lane_tag_t               tag_r   [0:N_ENT-1];
  logic [DEN_W-1:0]        den_nxt, den_r;
  logic                    deg_nxt;
  logic                    deg_r   [0:LANE_LAT];

  always_comb begin
    num[0] = n0_r;
    num[1] = -(p_r + q_r);
    num[2] = -(q_r + r_r);
    num[3] = p_r;
    num[4] = q_r;
    num[5] = r_r;
    for (int i = 0; i < N_ENT; i++) begin
      mag_nxt[i] = num[i][SUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
    end
    den_nxt = det_r[SUM_W-1] ? DEN_W'(-det_r) : DEN_W'(det_r);
    deg_nxt = (det_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ENT; i++) begin
        mag_r[i]     <= mag_nxt[i];
        tag_r[i].neg <= num[i][SUM_W-1];
        tag_r[i].deg <= deg_nxt;
      end
      den_r    <= den_nxt;
      deg_r[0] <= deg_nxt;
      for (int i = 1; i <= LANE_LAT; i++) deg_r[i] <= deg_r[i-1];
    end
  end

  // Divider lanes, one per unique entry
  logic signed [Q_W-1:0] k_lane [0:N_ENT-1];

  genvar g;
  generate
    for (g = 0; g < N_ENT; g++) begin : g_lane
      p1ts_div_lane u_lane (
        .clk (clk),
        .en  (en),
        .mag (mag_r[g]),
        .den (den_r),
        .tag (tag_r[g]),
        .k   (k_lane[g])
      );
    end
  endgenerate

  assign out_k00        = k_lane[0];
  assign out_k01        = k_lane[1];
  assign out_k02        = k_lane[2];
  assign out_k11        = k_lane[3];
  assign out_k12        = k_lane[4];
  assign out_k22        = k_lane[5];
  assign out_degenerate = deg_r[LANE_LAT];

`ifndef SYNTHESIS
  // Degenerate triangles carry all-zero entries
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_k00 == 0 && out_k01 == 0 && out_k02 == 0 &&
      out_k11 == 0 && out_k12 == 0 && out_k22 == 0)
    else $error("degenerate beat with nonzero entries");

  // Diagonal entries are never negative
  a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_k00[Q_W-1] && !out_k11[Q_W-1] && !out_k22[Q_W-1])
    else $error("negative diagonal entry");

  // A stalled result beat holds until taken (checked on k00, k22 and the degenerate flag)
  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_k00) && $stable(out_k22) && $stable(out_degenerate))
    else $error("result lost under stall");
`endif

endmodule

>>> tb/sv/p1_triangle_stiffness_test.sv
// ----------------------------------------------------------------------------
// p1_triangle_stiffness_test
// Streams triangles through the stiffness pipeline with random gaps on both
// channels and checks every result beat against an in-bench fixed-point
// predictor of the six unique matrix entries and the degenerate flag.
// ----------------------------------------------------------------------------
module p1_triangle_stiffness_test;
  timeunit 1ns;
  timeprecision 1ps;
  import p1ts_pkg::*;

  typedef struct {
    logic signed [Q_W-1:0] k [6];
    logic                  deg;
  } stiff_t;

  // Scoreboard: predicts entries for each accepted triangle, checks results
  class stiff_board;
    stiff_t pending[$];
    int     errors;

    // round(num * 2^15 / den), ties away from zero, clamped to Q16.16
    function automatic logic signed [Q_W-1:0] entry(longint num, longint unsigned den);
      logic neg;
      longint unsigned mag, q;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      q = ((mag << 16) + den) / (den << 1);
      if (neg) begin
        if (q > 64'd2147483648) q = 64'd2147483648;
        return Q_W'(-q);
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return Q_W'(q);
    endfunction

    function void note_triangle(logic signed [CRD_W-1:0] v[6]);
      longint a, b, c, d, det, p, q, r;
      longint unsigned den;
      stiff_t e;
      a = longint'(v[2]) - longint'(v[0]);
      b = longint'(v[3]) - longint'(v[1]);
      c = longint'(v[4]) - longint'(v[0]);
      d = longint'(v[5]) - longint'(v[1]);
      det = a * d - b * c;
      e.deg = (det == 0);
      foreach (e.k[i]) e.k[i] = '0;
      if (det != 0) begin
        p = c * c + d * d;
        q = -(a * c + b * d);
        r = a * a + b * b;
        den = det < 0 ? -det : det;
        e.k[0] = entry((c - a) * (c - a) + (d - b) * (d - b), den);
        e.k[1] = entry(-(p + q), den);
        e.k[2] = entry(-(q + r), den);
        e.k[3] = entry(p, den);
        e.k[4] = entry(q, den);
        e.k[5] = entry(r, den);
      end
      pending = {pending, e};
    endfunction

    function void check_result(logic signed [Q_W-1:0] k[6], logic deg);
      stiff_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      foreach (k[i])
        if (k[i] !== e.k[i]) begin
          $display("%0t: entry %0d expected %0d actual %0d", $realtime, i, e.k[i], k[i]);
          errors++;
        end
      if (deg !== e.deg) begin
        $display("%0t: degenerate expected %0b actual %0b", $realtime, e.deg, deg);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, out_degenerate;
  logic signed [CRD_W-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;
  logic signed [Q_W-1:0] out_k00, out_k01, out_k02, out_k11, out_k12, out_k22;

  stiff_board board;
  bit  feed_done;
  int  idle_cycles;

  p1_triangle_stiffness uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random coordinate: mostly full-range, sometimes extremes or small
  function automatic logic signed [CRD_W-1:0] rand_crd();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return CRD_W'($urandom_range(0, 255) - 128);
      default: return CRD_W'($urandom);
    endcase
  endfunction

  // Drive one triangle beat, hold until accepted; called at a falling edge
  task automatic send_triangle(logic signed [CRD_W-1:0] v[6]);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    {in_x0, in_y0, in_x1, in_y1, in_x2, in_y2} <= {v[0], v[1], v[2], v[3], v[4], v[5]};
    do @(posedge clk); while (!in_ready);
    board.note_triangle(v);
    @(negedge clk);
  endtask

  // Result sink with random back-pressure
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 40) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) || feed_done ? 1'b1 : 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic signed [Q_W-1:0] k[6];
    if (rst_n && out_valid && out_ready) begin
      k = '{out_k00, out_k01, out_k02, out_k11, out_k12, out_k22};
      board.check_result(k, out_degenerate);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [CRD_W-1:0] v[6];
    board = new();
    in_valid = 0;
    {in_x0, in_y0, in_x1, in_y1, in_x2, in_y2} = '0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: unit triangle, clockwise twin, degenerate, extremes
    v = '{0, 0, 16'sd4096, 0, 0, 16'sd4096};                       send_triangle(v);
    v = '{0, 0, 0, 16'sd4096, 16'sd4096, 0};                       send_triangle(v);
    v = '{0, 0, 0, 0, 0, 0};                                       send_triangle(v);
    v = '{1, 1, 2, 2, 3, 3};                                       send_triangle(v);
    v = '{0, 0, 1, 0, 0, 1};                                       send_triangle(v);
    v = '{0, 0, 16'sh7fff, 0, 0, 1};                               send_triangle(v);
    v = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    send_triangle(v);
    v = '{16'sh8000, 0, 16'sh7fff, 0, 0, 1};                       send_triangle(v);
    v = '{0, 0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8001};       send_triangle(v);
    v = '{0, 0, 3, 0, 0, 2};                                       send_triangle(v);
    v = '{-1, -1, -1, -1, -1, -1};                                 send_triangle(v);

    // Random triangles, some forced collinear
    repeat (600) begin
      foreach (v[i]) v[i] = rand_crd();
      if ($urandom_range(0, 19) == 0) begin
        v[4] = v[2]; v[5] = v[3];
      end
      send_triangle(v);
    end
    in_valid <= 0;
    feed_done = 1;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
